[rtl/core/assert_macros.svh]
// assertion helpers for the rtl files, included by mmsv_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define MMSV_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define MMSV_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[rtl/core/mmsv_pkg.sv]
// ----------------------------------------------------------------------------
// mmsv_pkg
// shared types and constants of the min-max svpwm on-time block
// ----------------------------------------------------------------------------
package mmsv_pkg;

  localparam int COUNT_BITS = 16;
  localparam int REF_BITS   = 20;
  localparam int PROD_BITS  = 52;
  localparam int CFG_IDX_BITS = 8;
  localparam int CFG_DATA_BITS = 32;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEAD   = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN   = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TICKS  = 8'd3;

  localparam logic [19:0] PERIOD_RST = 20'd100000;
  localparam logic [15:0] DEAD_RST   = 16'd2000;
  localparam logic [31:0] GAIN_RST   = 32'd65536;
  localparam logic [31:0] TICKS_RST  = 32'd16777216;

  typedef struct packed {
    logic signed [REF_BITS-1:0] phase_a_ref;
    logic signed [REF_BITS-1:0] phase_b_ref;
    logic signed [REF_BITS-1:0] phase_c_ref;
  } in_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] on_ticks_a;
    logic [COUNT_BITS-1:0] on_ticks_b;
    logic [COUNT_BITS-1:0] on_ticks_c;
    logic                  overmodulated;
  } out_t;

  // raw ref * gain products, one word of the queue
  typedef struct packed {
    logic signed [PROD_BITS-1:0] prod_a;
    logic signed [PROD_BITS-1:0] prod_b;
    logic signed [PROD_BITS-1:0] prod_c;
  } q_word_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_MUL,
    FS_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_MM,
    BS_SPR,
    BS_DIV,
    BS_MLO,
    BS_MHI,
    BS_SADD,
    BS_OFF,
    BS_VADD,
    BS_TLO,
    BS_THI,
    BS_TADD,
    BS_DONE
  } back_state_t;

endpackage

[rtl/core/minmax_svpwm_on_time.sv]
// ----------------------------------------------------------------------------
// minmax_svpwm_on_time
// min-max zero-sequence svpwm compare counts from three phase references
// ----------------------------------------------------------------------------
// One word in gives one word out. The front forms the three ref * gain
// products on one shared multiplier, one phase at a time, and takes no new
// word until it has pushed the last one into the two-word queue, waiting
// while the queue is full. The back is a sequencer around a second 32x32
// multiplier; with overmodulation it adds a 32-step restoring divide for the
// scale factor and a two-part multiply for each scaled time, so the back sets the sustained
// rate. Configuration writes are meant for idle periods only.
module minmax_svpwm_on_time (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  mmsv_pkg::in_t                         in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output mmsv_pkg::out_t                        out_data,
  input  logic                                  cfg_we,
  input  logic [mmsv_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [mmsv_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

  logic [19:0] period_r;
  logic [15:0] dead_r;
  logic [31:0] gain_r;
  logic [31:0] tpn_r;

  logic              push, pop, q_full, q_empty;
  mmsv_pkg::q_word_t push_data, pop_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= mmsv_pkg::PERIOD_RST;
      dead_r   <= mmsv_pkg::DEAD_RST;
      gain_r   <= mmsv_pkg::GAIN_RST;
      tpn_r    <= mmsv_pkg::TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mmsv_pkg::CFG_PERIOD: period_r <= cfg_wdata[19:0];
        mmsv_pkg::CFG_DEAD:   dead_r   <= cfg_wdata[15:0];
        mmsv_pkg::CFG_GAIN:   gain_r   <= cfg_wdata;
        mmsv_pkg::CFG_TICKS:  tpn_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  mmsv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .gain      (gain_r),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  mmsv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  mmsv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .period    (period_r),
    .dead      (dead_r),
    .tpn       (tpn_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/core/mmsv_front.sv]
// ----------------------------------------------------------------------------
// mmsv_front
// takes an input word and forms the three ref * gain products
// ----------------------------------------------------------------------------
module mmsv_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mmsv_pkg::in_t       in_data,
  input  logic [31:0]         gain,
  output logic                push,
  output mmsv_pkg::q_word_t   push_data,
  input  logic                q_full
);

  mmsv_pkg::front_state_t state_r, state_nxt;
  mmsv_pkg::in_t          ref_r;
  mmsv_pkg::q_word_t      prod_r;
  logic [1:0]             cnt_r;
  logic signed [mmsv_pkg::REF_BITS-1:0] ref_sel;
  logic signed [mmsv_pkg::REF_BITS+32:0] prod;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmsv_pkg::FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and handshake
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    push      = 1'b0;
    case (state_r)
      mmsv_pkg::FS_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = mmsv_pkg::FS_MUL;
        end
      end
      mmsv_pkg::FS_MUL: begin
        if (cnt_r == 2'd2) begin
          state_nxt = mmsv_pkg::FS_PUSH;
        end
      end
      mmsv_pkg::FS_PUSH: begin
        if (!q_full) begin
          push      = 1'b1;
          state_nxt = mmsv_pkg::FS_IDLE;
        end
      end
      default: state_nxt = mmsv_pkg::FS_IDLE;
    endcase
  end

  // one shared multiplier, one phase per cycle
  always_comb begin
    case (cnt_r)
      2'd0:    ref_sel = ref_r.phase_a_ref;
      2'd1:    ref_sel = ref_r.phase_b_ref;
      default: ref_sel = ref_r.phase_c_ref;
    endcase
  end

  assign prod = ref_sel * $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (state_r == mmsv_pkg::FS_IDLE) begin
      cnt_r <= 2'd0;
    end else if (state_r == mmsv_pkg::FS_MUL) begin
      cnt_r <= cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == mmsv_pkg::FS_IDLE && in_valid) begin
      ref_r <= in_data;
    end
    if (state_r == mmsv_pkg::FS_MUL) begin
      case (cnt_r)
        2'd0:    prod_r.prod_a <= prod[mmsv_pkg::PROD_BITS-1:0];
        2'd1:    prod_r.prod_b <= prod[mmsv_pkg::PROD_BITS-1:0];
        default: prod_r.prod_c <= prod[mmsv_pkg::PROD_BITS-1:0];
      endcase
    end
  end

  assign push_data = prod_r;

endmodule

[rtl/core/mmsv_queue.sv]
// ----------------------------------------------------------------------------
// mmsv_queue
// two-word queue between the front and the back
// ----------------------------------------------------------------------------
module mmsv_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mmsv_pkg::q_word_t push_data,
  input  logic              pop,
  output mmsv_pkg::q_word_t pop_data,
  output logic              full,
  output logic              empty
);

  mmsv_pkg::q_word_t mem_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/core/mmsv_back.sv]
// ----------------------------------------------------------------------------
// mmsv_back
// min-max, overmodulation scaling, centering and tick conversion
// ----------------------------------------------------------------------------
module mmsv_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  mmsv_pkg::q_word_t q_data,
  output logic              pop,
  input  logic [19:0]       period,
  input  logic [15:0]       dead,
  input  logic [31:0]       tpn,
  output logic              out_valid,
  input  logic              out_stall,
  output mmsv_pkg::out_t    out_data
);

  `include "assert_macros.svh"

  mmsv_pkg::back_state_t state_r, state_nxt;

  logic signed [47:0] t_r [3];
  logic signed [47:0] hi_r, lo_r;
  logic [48:0]        spread_r;
  logic signed [51:0] tzero_r;
  logic               over_r;
  logic [49:0]        rem_r;
  logic [31:0]        k_r;
  logic [4:0]         cnt_r;
  logic [1:0]         idx_r;
  logic signed [51:0] off_r;
  logic signed [52:0] v_r;
  logic [63:0]        p_r, q_r;
  logic [mmsv_pkg::COUNT_BITS-1:0] ticks_r [3];
  logic               out_valid_r;
  mmsv_pkg::out_t     out_data_r;

  logic               out_free, load_out;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  logic signed [47:0] t_new [3];
  logic signed [47:0] hi_ab, lo_ab;
  logic signed [47:0] val, t_sel;
  logic [47:0]        mag;
  logic [48:0]        neg49;
  logic [64:0]        rnd;
  logic [48:0]        sc_sum;
  logic [47:0]        sc_mag;
  logic signed [47:0] sc_val;
  logic [48:0]        spread;
  logic signed [51:0] tzero;
  logic signed [51:0] twod;
  logic               over;
  logic signed [36:0] num;
  logic [49:0]        rem2;
  logic               rem_ge;
  logic [52:0]        mid;
  logic [44:0]        tick_rnd;
  logic [mmsv_pkg::COUNT_BITS-1:0] tick_sat;

  assign out_free = !out_valid_r || !out_stall;
  assign load_out = (state_r == mmsv_pkg::BS_DONE) && out_free;
  assign pop      = (state_r == mmsv_pkg::BS_IDLE) && !q_empty;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmsv_pkg::BS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mmsv_pkg::BS_IDLE: if (!q_empty) state_nxt = mmsv_pkg::BS_MM;
      mmsv_pkg::BS_MM:   state_nxt = mmsv_pkg::BS_SPR;
      mmsv_pkg::BS_SPR: begin
        if (over && spread != '0) begin
          state_nxt = mmsv_pkg::BS_DIV;
        end else begin
          state_nxt = mmsv_pkg::BS_OFF;
        end
      end
      mmsv_pkg::BS_DIV:  if (cnt_r == 5'd31) state_nxt = mmsv_pkg::BS_MLO;
      mmsv_pkg::BS_MLO:  state_nxt = mmsv_pkg::BS_MHI;
      mmsv_pkg::BS_MHI:  state_nxt = mmsv_pkg::BS_SADD;
      mmsv_pkg::BS_SADD: begin
        if (idx_r == 2'd3) begin
          state_nxt = mmsv_pkg::BS_OFF;
        end else begin
          state_nxt = mmsv_pkg::BS_MLO;
        end
      end
      mmsv_pkg::BS_OFF:  state_nxt = mmsv_pkg::BS_VADD;
      mmsv_pkg::BS_VADD: state_nxt = mmsv_pkg::BS_TLO;
      mmsv_pkg::BS_TLO:  state_nxt = mmsv_pkg::BS_THI;
      mmsv_pkg::BS_THI:  state_nxt = mmsv_pkg::BS_TADD;
      mmsv_pkg::BS_TADD: begin
        if (idx_r == 2'd2) begin
          state_nxt = mmsv_pkg::BS_DONE;
        end else begin
          state_nxt = mmsv_pkg::BS_VADD;
        end
      end
      mmsv_pkg::BS_DONE: if (out_free) state_nxt = mmsv_pkg::BS_IDLE;
      default:           state_nxt = mmsv_pkg::BS_IDLE;
    endcase
  end

  // products to rounded times
  assign t_new[0] = 48'((q_data.prod_a + 52'sd8) >>> 4);
  assign t_new[1] = 48'((q_data.prod_b + 52'sd8) >>> 4);
  assign t_new[2] = 48'((q_data.prod_c + 52'sd8) >>> 4);

  // larger and smaller of phases a and b
  assign hi_ab = (t_r[0] > t_r[1]) ? t_r[0] : t_r[1];
  assign lo_ab = (t_r[0] > t_r[1]) ? t_r[1] : t_r[0];

  // spread, zero time and overmodulation test
  assign spread = 49'(49'(hi_r) - 49'(lo_r));
  assign tzero  = $signed({16'b0, period, 16'b0}) - $signed({3'b0, spread});
  assign twod   = $signed({19'b0, dead, 17'b0});
  assign over   = tzero < twod;
  assign num    = $signed({1'b0, period, 16'b0}) - $signed({4'b0, dead, 17'b0});

  // restoring divide step
  assign rem2   = {rem_r[48:0], 1'b0};
  assign rem_ge = rem2 >= {1'b0, spread_r};

  // scaling operand, magnitude and rounded product sum
  assign t_sel  = t_r[idx_r];
  assign val    = (idx_r == 2'd3) ? lo_r : t_sel;
  assign neg49  = 49'(-$signed({val[47], val}));
  assign mag    = val[47] ? neg49[47:0] : val[47:0];
  assign rnd    = {1'b0, p_r} + 65'h0_8000_0000;
  assign sc_sum = 49'(q_r) + {16'b0, rnd[64:32]};
  assign sc_mag = sc_sum[47:0];
  assign sc_val = val[47] ? -$signed(sc_mag) : $signed(sc_mag);

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      mmsv_pkg::BS_MLO: begin
        mul_a = mag[31:0];
        mul_b = k_r;
      end
      mmsv_pkg::BS_MHI: begin
        mul_a = {16'b0, mag[47:32]};
        mul_b = k_r;
      end
      mmsv_pkg::BS_TLO: begin
        mul_a = v_r[31:0];
        mul_b = tpn;
      end
      mmsv_pkg::BS_THI: begin
        mul_a = {12'b0, v_r[51:32]};
        mul_b = tpn;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // tick rounding and saturation
  assign mid      = 53'(q_r) + {21'b0, p_r[63:32]};
  assign tick_rnd = 45'((mid + 53'd128) >> 8);
  assign tick_sat = (v_r <= 0) ? '0 :
                    (tick_rnd > 45'({mmsv_pkg::COUNT_BITS{1'b1}})) ?
                    {mmsv_pkg::COUNT_BITS{1'b1}} : tick_rnd[mmsv_pkg::COUNT_BITS-1:0];

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      mmsv_pkg::BS_IDLE: begin
        t_r[0] <= t_new[0];
        t_r[1] <= t_new[1];
        t_r[2] <= t_new[2];
      end
      mmsv_pkg::BS_MM: begin
        hi_r <= (t_r[2] > hi_ab) ? t_r[2] : hi_ab;
        lo_r <= (t_r[2] < lo_ab) ? t_r[2] : lo_ab;
      end
      mmsv_pkg::BS_SPR: begin
        spread_r <= spread;
        over_r   <= over;
        tzero_r  <= over ? twod : tzero;
        rem_r    <= num[36] ? '0 : {13'b0, num};
        k_r      <= '0;
        cnt_r    <= '0;
        idx_r    <= '0;
      end
      mmsv_pkg::BS_DIV: begin
        cnt_r <= cnt_r + 5'd1;
        rem_r <= rem_ge ? (rem2 - {1'b0, spread_r}) : rem2;
        k_r   <= {k_r[30:0], rem_ge};
      end
      mmsv_pkg::BS_MLO: p_r <= prod;
      mmsv_pkg::BS_MHI: q_r <= prod;
      mmsv_pkg::BS_SADD: begin
        if (idx_r == 2'd3) begin
          lo_r <= sc_val;
        end else begin
          t_r[idx_r] <= sc_val;
        end
        idx_r <= idx_r + 2'd1;
      end
      mmsv_pkg::BS_OFF: begin
        off_r <= (tzero_r >>> 1) - 52'(lo_r);
        idx_r <= '0;
      end
      mmsv_pkg::BS_VADD: v_r <= 53'(t_sel) + 53'(off_r);
      mmsv_pkg::BS_TLO:  p_r <= prod;
      mmsv_pkg::BS_THI:  q_r <= prod;
      mmsv_pkg::BS_TADD: begin
        ticks_r[idx_r] <= tick_sat;
        idx_r          <= idx_r + 2'd1;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.on_ticks_a    <= ticks_r[0];
      out_data_r.on_ticks_b    <= ticks_r[1];
      out_data_r.on_ticks_c    <= ticks_r[2];
      out_data_r.overmodulated <= over_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MMSV_ASSERT(a_div_over, (state_r != mmsv_pkg::BS_DIV) || (over_r && spread_r != '0),
               "divide without overmodulation")
  `MMSV_ASSERT(a_rem_below, (state_r != mmsv_pkg::BS_DIV) || (rem_r < {1'b0, spread_r}),
               "divide remainder not below divisor")
  `MMSV_ASSERT_NEXT(a_load_valid, load_out, out_valid_r,
                    "result load did not raise valid")

endmodule

[tb/tb_minmax_svpwm_on_time.sv]
// ----------------------------------------------------------------------------
// tb_minmax_svpwm_on_time
// self-checking bench for the min-max svpwm on-time block: a predictor
// computes the expected compare counts of each accepted word, results are
// checked in order under several register settings and idle/stall mixes
// ----------------------------------------------------------------------------
module tb_minmax_svpwm_on_time;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 100;

  // predictor and in-order store of expected counts
  class on_time_scoreboard;
    longint unsigned period_ns, dead_ns, gain, ticks;
    mmsv_pkg::out_t expected_q[$];
    int fails;

    function new();
      period_ns = mmsv_pkg::PERIOD_RST;
      dead_ns   = mmsv_pkg::DEAD_RST;
      gain      = mmsv_pkg::GAIN_RST;
      ticks     = mmsv_pkg::TICKS_RST;
      fails     = 0;
    endfunction

    function void set_reg(logic [mmsv_pkg::CFG_IDX_BITS-1:0] idx,
                          logic [mmsv_pkg::CFG_DATA_BITS-1:0] val);
      case (idx)
        mmsv_pkg::CFG_PERIOD: period_ns = val[19:0];
        mmsv_pkg::CFG_DEAD:   dead_ns   = val[15:0];
        mmsv_pkg::CFG_GAIN:   gain      = val;
        mmsv_pkg::CFG_TICKS:  ticks     = val;
        default: ;
      endcase
    endfunction

    // |t| * k / 2^32 rounded half up, sign kept
    function longint scale_time(longint t, longint unsigned k);
      longint unsigned mag, hi, lo, r;
      mag = (t < 0) ? -t : t;
      hi  = mag >> 32;
      lo  = mag & 64'hFFFF_FFFF;
      r   = hi * k + ((lo * k + 64'h8000_0000) >> 32);
      return (t < 0) ? -longint'(r) : longint'(r);
    endfunction

    function logic [mmsv_pkg::COUNT_BITS-1:0] time_to_ticks(longint t);
      longint unsigned u, hi, lo, p, mid, r, maxc;
      maxc = (64'd1 << mmsv_pkg::COUNT_BITS) - 1;
      if (t <= 0) return '0;
      u   = t;
      hi  = u >> 32;
      lo  = u & 64'hFFFF_FFFF;
      p   = lo * ticks;
      mid = hi * ticks + (p >> 32);
      r   = (mid + 128) >> 8;
      return (r > maxc) ? maxc[mmsv_pkg::COUNT_BITS-1:0] : r[mmsv_pkg::COUNT_BITS-1:0];
    endfunction

    function mmsv_pkg::out_t predict(mmsv_pkg::in_t d);
      longint t[3];
      longint hi_t, lo_t, spread, tzero, twod, period, nums, off;
      longint unsigned rem, den, k;
      mmsv_pkg::out_t o;
      t[0] = (longint'(d.phase_a_ref) * longint'(gain) + 8) >>> 4;
      t[1] = (longint'(d.phase_b_ref) * longint'(gain) + 8) >>> 4;
      t[2] = (longint'(d.phase_c_ref) * longint'(gain) + 8) >>> 4;
      hi_t = (t[0] > t[1]) ? t[0] : t[1];
      lo_t = (t[0] > t[1]) ? t[1] : t[0];
      if (t[2] > hi_t) hi_t = t[2];
      if (t[2] < lo_t) lo_t = t[2];
      period = longint'(period_ns) << 16;
      spread = hi_t - lo_t;
      tzero  = period - spread;
      twod   = longint'(2 * dead_ns) << 16;
      o.overmodulated = 1'b0;
      // overmodulation: shrink all times so the zero time is twice the dead time
      if (tzero < twod) begin
        o.overmodulated = 1'b1;
        if (spread > 0) begin
          nums = period - twod;
          rem  = (nums > 0) ? nums : 0;
          den  = spread;
          k    = 0;
          for (int s = 0; s < 32; s++) begin
            rem = rem << 1;
            k   = k << 1;
            if (rem >= den) begin
              rem = rem - den;
              k   = k | 1;
            end
          end
          for (int i = 0; i < 3; i++) t[i] = scale_time(t[i], k);
          lo_t = scale_time(lo_t, k);
        end
        tzero = twod;
      end
      off = (tzero >>> 1) - lo_t;
      o.on_ticks_a = time_to_ticks(t[0] + off);
      o.on_ticks_b = time_to_ticks(t[1] + off);
      o.on_ticks_c = time_to_ticks(t[2] + off);
      return o;
    endfunction

    function void note_input(mmsv_pkg::in_t d);
      expected_q.push_back(predict(d));
    endfunction

    function void check_result(mmsv_pkg::out_t got);
      mmsv_pkg::out_t exp_w;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        fails++;
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.on_ticks_a !== exp_w.on_ticks_a) begin
        $display("%0t: on_ticks_a expected %0d actual %0d", $time, exp_w.on_ticks_a,
                 got.on_ticks_a);
        fails++;
      end
      if (got.on_ticks_b !== exp_w.on_ticks_b) begin
        $display("%0t: on_ticks_b expected %0d actual %0d", $time, exp_w.on_ticks_b,
                 got.on_ticks_b);
        fails++;
      end
      if (got.on_ticks_c !== exp_w.on_ticks_c) begin
        $display("%0t: on_ticks_c expected %0d actual %0d", $time, exp_w.on_ticks_c,
                 got.on_ticks_c);
        fails++;
      end
      if (got.overmodulated !== exp_w.overmodulated) begin
        $display("%0t: overmodulated expected %0d actual %0d", $time, exp_w.overmodulated,
                 got.overmodulated);
        fails++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  mmsv_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mmsv_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [mmsv_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [mmsv_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;

  on_time_scoreboard sb = new();
  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  minmax_svpwm_on_time DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // result side: check, random stall, watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // present one word, hold until accepted, then maybe idle
  task automatic send_word(mmsv_pkg::in_t d);
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(d);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= mmsv_pkg::in_t'(60'({$urandom, $urandom}));
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
  endtask

  // let every expected word come back, then let the clock run on with no input
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [mmsv_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [mmsv_pkg::CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // full register set, with junk upper bits and one write to an unused index
  task automatic load_config(logic [19:0] p, logic [15:0] dt, logic [31:0] g, logic [31:0] tk);
    drain();
    write_reg(mmsv_pkg::CFG_PERIOD, {$urandom_range(4095), p});
    write_reg(mmsv_pkg::CFG_DEAD, {$urandom_range(65535), dt});
    write_reg(mmsv_pkg::CFG_GAIN, g);
    write_reg(mmsv_pkg::CFG_TICKS, tk);
    write_reg(mmsv_pkg::CFG_TICKS + 1 + $urandom_range(200), $urandom);
    cfg_we <= 1'b0;
  endtask

  function automatic mmsv_pkg::in_t rand_word();
    mmsv_pkg::in_t d;
    int pick;
    pick = $urandom_range(9);
    d = mmsv_pkg::in_t'(60'({$urandom, $urandom}));
    if (pick < 4) begin
      d.phase_a_ref = $urandom_range(16383) - 8192;
      d.phase_b_ref = $urandom_range(16383) - 8192;
      d.phase_c_ref = $urandom_range(16383) - 8192;
    end else if (pick == 8) begin
      d.phase_b_ref = d.phase_a_ref;
      d.phase_c_ref = d.phase_a_ref;
    end else if (pick == 9) begin
      d.phase_a_ref = $urandom_range(1) ? 20'sh7FFFF : 20'sh80000;
      d.phase_b_ref = $urandom_range(1) ? 20'sh7FFFF : 20'sh80000;
    end
    return d;
  endfunction

  task automatic directed_words();
    send_word('{20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF});
    send_word('{20'sh80000, 20'sh80000, 20'sh80000});
    send_word('{20'sh7FFFF, 20'sh80000, 20'sh00000});
    send_word('{20'sh80000, 20'sh00000, 20'sh7FFFF});
    send_word('{20'sh00000, 20'sh00000, 20'sh00000});
    send_word('{20'sh00001, 20'shFFFFF, 20'sh00008});
    send_word('{20'sh01234, 20'shFEDCC, 20'sh00100});
    send_word('{20'sh55555, 20'shAAAAA, 20'sh0F0F0});
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset registers, heavy overmodulation, period below twice dead time
    directed_words();
    load_config(20'd100000, 16'd2000, 32'd196608, 32'd16777216);
    directed_words();
    load_config(20'd1000, 16'd65535, 32'd327680, 32'd8388608);
    directed_words();

    // random phases across register settings and idle/stall mixes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_config(mmsv_pkg::PERIOD_RST, mmsv_pkg::DEAD_RST, mmsv_pkg::GAIN_RST,
                       mmsv_pkg::TICKS_RST);
        1: load_config(20'd100000, 16'd2000, 32'd196608, 32'd16777216);
        2: load_config(20'hFFFFF, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        3: load_config(20'd1000, 16'd65535, 32'd327680, 32'd8388608);
        4: load_config(20'd0, 16'd0, 32'd0, 32'd0);
        5: load_config(20'd50000, 16'd1000, 32'd131072, 32'd67108864);
        6: load_config(20'd20000, 16'd500, 32'd262144, 32'd4194304);
        default: load_config(20'd100000, 16'd2000, 32'd12345, 32'd25165824);
      endcase
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      for (int n = 0; n < 75; n++) send_word(rand_word());
    end

    drain();
    if (sb.fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/mmsv_pkg.sv
rtl/core/mmsv_front.sv
rtl/core/mmsv_queue.sv
rtl/core/mmsv_back.sv
rtl/core/minmax_svpwm_on_time.sv
tb/tb_minmax_svpwm_on_time.sv
